// ===== design/tccw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	// screen geometry defaults
	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	// field widths
	localparam int CHAR_W  = 8;
	localparam int INDEX_W = 11;
	localparam int POS_W   = 11;
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;
	localparam int COLOR_W = 4;

	// request types on the input stream
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// control characters
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	// colour register reset values
	localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
	localparam logic [CELL_W-1:0]  RESET_BLANK = {BG_RESET, FG_RESET, BLANK_CHAR};

	// register indexes (paddr[2])
	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// classified command kinds
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_PRINT     = 3'd0;
	localparam kind_t KIND_NEWLINE   = 3'd1;
	localparam kind_t KIND_RETURN    = 3'd2;
	localparam kind_t KIND_BACKSPACE = 3'd3;
	localparam kind_t KIND_CLEAR     = 3'd4;
	localparam kind_t KIND_READ      = 3'd5;
	localparam kind_t KIND_NOP       = 3'd6;

	typedef struct packed {
		kind_t              kind;
		logic [CHAR_W-1:0]  ch;
		logic [INDEX_W-1:0] idx;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/text_console_char_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console engine: cursor handling, scroll and clear on a ROWS x COLUMNS
// screen of 16-bit character/attribute cells.
// ----------------------------------------------------------------------------
// After reset the block blanks the whole screen, one cell a cycle, with
// s_tready low; the APB registers can be written meanwhile. A request word
// then goes through a decode front and a two-deep command queue to the
// execution back, which owns a single-write-port cell memory. A printable,
// control or unused request goes from the idle state to the response state,
// a cell read through a read state between them (registered memory read). A
// clear writes every cell. A newline or line wrap on the bottom row scrolls:
// one cell copied per cycle through the memory port, then the bottom row
// blanked. One result word per request; the output register lets the next
// request proceed while a result waits to be taken.
module text_console_char_writer #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	// request stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
	input  wire  [1:0]  s_tuser,   // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // cursor_pos[10:0], cell_data[26:11], zero pad
	// APB register port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tccw_pkg::*;

	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               reg_wr;
	logic               init_busy;
	logic               q_full;
	logic               push;
	logic               pop;
	logic               head_valid;
	cmd_t               push_cmd;
	cmd_t               head;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (reg_wr) begin
			if (paddr[2] == REG_FG)
				fg_q <= pwdata[COLOR_W-1:0];
			else
				bg_q <= pwdata[COLOR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_BG) ? {28'd0, bg_q} : {28'd0, fg_q};

	tccw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.init_busy(init_busy),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	tccw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	tccw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      ({bg_q, fg_q}),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

// ===== design/tccw_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_front
// Input side: takes request words, decodes them into command kinds and pushes
// them into the command queue.
// ----------------------------------------------------------------------------
module tccw_front #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [23:0]         s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
	input  wire  [1:0]          s_tuser,   // req_type[1:0]
	input  wire                 init_busy,
	input  wire                 q_full,
	output logic                push,
	output tccw_pkg::cmd_t      cmd
);
	import tccw_pkg::*;

	localparam int CELL_COUNT = ROWS * COLUMNS;

	logic [CHAR_W-1:0]  ch;
	logic [INDEX_W-1:0] idx;
	kind_t              kind;

	assign ch  = s_tdata[CHAR_W-1:0];
	assign idx = s_tdata[CHAR_W+INDEX_W-1:CHAR_W];

	always_comb begin
		case (s_tuser)
			REQ_PUT: begin
				if (ch == CHAR_LF)
					kind = KIND_NEWLINE;
				else if (ch == CHAR_CR)
					kind = KIND_RETURN;
				else if (ch == CHAR_BS)
					kind = KIND_BACKSPACE;
				else
					kind = KIND_PRINT;
			end
			REQ_CLEAR: kind = KIND_CLEAR;
			// reads past the screen return zero and touch nothing
			REQ_READ: kind = (int'(idx) < CELL_COUNT) ? KIND_READ : KIND_NOP;
			default: kind = KIND_NOP;
		endcase
	end

	assign s_tready = !init_busy && !q_full;
	assign push     = s_tvalid && s_tready;

	assign cmd.kind = kind;
	assign cmd.ch   = ch;
	assign cmd.idx  = idx;

endmodule
`default_nettype wire

// ===== design/tccw_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module tccw_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  tccw_pkg::cmd_t      push_cmd,
	input  wire                 pop,
	output logic                full,
	output logic                head_valid,
	output tccw_pkg::cmd_t      head
);
	import tccw_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// ===== design/tccw_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_back
// Execution side: cursor, screen cell memory, scroll/clear sequencer and the
// result output register.
// ----------------------------------------------------------------------------
module tccw_back #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [tccw_pkg::ATTR_W-1:0] attr,
	input  wire                         head_valid,
	input  tccw_pkg::cmd_t              head,
	output logic                        pop,
	output logic                        init_busy,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [31:0]                 m_tdata   // cursor_pos[10:0], cell_data[26:11], zero pad
);
	import tccw_pkg::*;

	localparam int N      = ROWS * COLUMNS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(N);
	localparam int CNT_W  = $clog2(N + 1);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_CLEAR  = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_BLANK  = 3'd5;
	localparam logic [2:0] ST_RESP   = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] lin_q;
	logic              copy_v_q;
	logic [ADDR_W-1:0] dst_q;
	logic [CELL_W-1:0] resp_data_q;
	logic              out_v_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [CELL_W-1:0] out_data_q;

	logic [CELL_W-1:0] mem [N];
	logic [CELL_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr;

	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [CELL_W-1:0] wd;
	logic [CELL_W-1:0] blank_cell;
	logic              col_last;
	logic              row_last;
	logic              fill_last;
	logic              out_load;

	assign pop        = (state_q == ST_IDLE) && head_valid;
	assign init_busy  = (state_q == ST_INIT);
	assign blank_cell = {attr, BLANK_CHAR};
	assign col_last   = (col_q == COL_W'(COLUMNS - 1));
	assign row_last   = (row_q == ROW_W'(ROWS - 1));
	assign fill_last  = (cnt_q == CNT_W'(N - 1));
	assign out_load   = (state_q == ST_RESP) && (!out_v_q || m_tready);
	assign rd_addr    = (state_q == ST_SCROLL) ? cnt_q[ADDR_W-1:0] : ADDR_W'(head.idx);

	// single write port: pending scroll copy first, then fills, then puts
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (copy_v_q) begin
			we = 1'b1;
			wa = dst_q;
			wd = rd_q;
		end else begin
			case (state_q)
				ST_INIT: begin
					we = 1'b1;
					wa = cnt_q[ADDR_W-1:0];
					wd = RESET_BLANK;
				end
				ST_CLEAR, ST_BLANK: begin
					we = 1'b1;
					wa = cnt_q[ADDR_W-1:0];
					wd = blank_cell;
				end
				ST_IDLE: begin
					if (pop && head.kind == KIND_PRINT) begin
						we = 1'b1;
						wa = lin_q;
						wd = {attr, head.ch};
					end else if (pop && head.kind == KIND_BACKSPACE) begin
						we = 1'b1;
						wa = (col_q != '0) ? ADDR_W'(lin_q - 1'b1) : lin_q;
						wd = blank_cell;
					end
				end
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			cnt_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			lin_q    <= '0;
			copy_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			copy_v_q <= 1'b0;
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;

			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (fill_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						case (head.kind)
							KIND_PRINT: begin
								if (col_last) begin
									col_q <= '0;
									if (row_last) begin
										lin_q   <= ADDR_W'(N - COLUMNS);
										cnt_q   <= CNT_W'(COLUMNS);
										state_q <= ST_SCROLL;
									end else begin
										row_q   <= row_q + 1'b1;
										lin_q   <= lin_q + 1'b1;
										state_q <= ST_RESP;
									end
								end else begin
									col_q   <= col_q + 1'b1;
									lin_q   <= lin_q + 1'b1;
									state_q <= ST_RESP;
								end
							end
							KIND_NEWLINE: begin
								col_q <= '0;
								if (row_last) begin
									lin_q   <= ADDR_W'(lin_q - ADDR_W'(col_q));
									cnt_q   <= CNT_W'(COLUMNS);
									state_q <= ST_SCROLL;
								end else begin
									row_q   <= row_q + 1'b1;
									lin_q   <= ADDR_W'(lin_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS));
									state_q <= ST_RESP;
								end
							end
							KIND_RETURN: begin
								col_q   <= '0;
								lin_q   <= ADDR_W'(lin_q - ADDR_W'(col_q));
								state_q <= ST_RESP;
							end
							KIND_BACKSPACE: begin
								if (col_q != '0) begin
									col_q <= col_q - 1'b1;
									lin_q <= lin_q - 1'b1;
								end
								state_q <= ST_RESP;
							end
							KIND_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							KIND_READ: state_q <= ST_READ;
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_READ: state_q <= ST_RESP;
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (fill_last) begin
						row_q   <= '0;
						col_q   <= '0;
						lin_q   <= '0;
						state_q <= ST_RESP;
					end
				end
				ST_SCROLL: begin
					// read row below, write it one row up in the next cycle
					if (cnt_q != CNT_W'(N)) begin
						copy_v_q <= 1'b1;
						cnt_q    <= cnt_q + 1'b1;
					end else begin
						cnt_q   <= CNT_W'(N - COLUMNS);
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (fill_last)
						state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (we)
			mem[wa] <= wd;
		dst_q <= ADDR_W'(cnt_q - CNT_W'(COLUMNS));
		if (pop)
			resp_data_q <= '0;
		else if (state_q == ST_READ)
			resp_data_q <= rd_q;
		if (out_load) begin
			out_pos_q  <= POS_W'(lin_q);
			out_data_q <= resp_data_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_data_q, out_pos_q};

	// linear cursor kept in step with row and column
	a_lin_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		int'(lin_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear cursor out of step with row/column");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLUMNS && int'(row_q) < ROWS)
		else $error("cursor off screen");

	a_copy_dst: assert property (@(posedge clk) disable iff (!arst_n)
		copy_v_q |-> int'(dst_q) < N - COLUMNS)
		else $error("scroll copy writes into bottom row");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result word raised outside response state");

endmodule
`default_nettype wire
